// File: src/egs_pkg.sv
// shared types and constants of the bytewise elgamal signer
`timescale 1ns / 1ps
package egs_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned HASH_BITS = 8;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_KEY = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR = 2'd2;

  // datapath steps; the serial ones run on the divider or the multiplier
  typedef enum logic [4:0] {
    STEP_NONE,
    STEP_GMOD,
    STEP_PMUL,
    STEP_PSQR,
    STEP_KMOD,
    STEP_EDIV,
    STEP_QMOD,
    STEP_EMUL,
    STEP_EFIN,
    STEP_UNUSE,
    STEP_CMOD,
    STEP_XMOD,
    STEP_HMOD,
    STEP_IMOD,
    STEP_RX,
    STEP_SMUL,
    STEP_OUT
  } step_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UNUSE,
    ST_GMOD,
    ST_PLOOP,
    ST_PMUL,
    ST_PSQR,
    ST_KMOD,
    ST_ELOOP,
    ST_EDIV,
    ST_QMOD,
    ST_EMUL,
    ST_EFIN,
    ST_CHECK,
    ST_CMOD,
    ST_XMOD,
    ST_HMOD,
    ST_IMOD,
    ST_RX,
    ST_SMUL,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    step_e step;
    logic  launch;
    logic  write;
    logic  accept;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic start;
    logic e_zero;
    logic e_bit;
    logic r1_zero;
    logic bad;
    logic unit_done;
    logic out_free;
  } sts_t;

endpackage

// File: src/elgamal_bytewise_signer.sv
// top level of the bytewise elgamal signer
`timescale 1ns / 1ps
// Each request signs one hash byte h as s = k^-1 * (h - r*x) mod (p-1) and returns it with
// r = g^k mod p; a request with tuser set first loads nonce k, computes r by square and
// multiply and k^-1 by extended Euclid, and keeps both for later bytes. All work runs on one
// bit-serial divider and one bit-serial modular multiplier. A byte request with a good nonce
// runs four reductions and two multiplications; a bad or missing nonce gives status 1.
// A start request adds two reductions (g mod p and k mod p-1), up to two multiplications
// and a decision state per exponent bit, and three serial operations plus a decision state
// per Euclid step. Requests are taken one at a time; a finished result waits in the output
// register while the next request is accepted.
module elgamal_bytewise_signer #(
  parameter int unsigned WORD_BITS = egs_pkg::WORD_BITS,
  localparam int unsigned SDW = ((WORD_BITS + egs_pkg::HASH_BITS + 7) / 8) * 8,
  localparam int unsigned MDW = ((2 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [egs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0]             cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [SDW-1:0]                   s_axis_tdata,  // nonce, hash_byte
  input  logic                             s_axis_tuser,  // start_req
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [MDW-1:0]                   m_axis_tdata,  // signature_part, commitment
  output logic                             m_axis_tuser   // status
);

  egs_pkg::cmd_t        cmd;
  egs_pkg::sts_t        sts;
  logic [WORD_BITS-1:0] sig, commit;

  egs_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  egs_datapath #(
    .W (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_start_i   (s_axis_tuser),
    .in_nonce_i   (s_axis_tdata[WORD_BITS-1:0]),
    .in_hash_i    (s_axis_tdata[WORD_BITS+egs_pkg::HASH_BITS-1:WORD_BITS]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_sig_o    (sig),
    .out_commit_o (commit),
    .out_status_o (m_axis_tuser)
  );

  always_comb begin
    m_axis_tdata                            = '0;
    m_axis_tdata[WORD_BITS-1:0]             = sig;
    m_axis_tdata[2*WORD_BITS-1:WORD_BITS]   = commit;
  end

endmodule

// File: src/egs_datapath.sv
// datapath: registers, serial divider and serial modular multiplier
`timescale 1ns / 1ps
module egs_datapath #(
  parameter int unsigned W = egs_pkg::WORD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  egs_pkg::cmd_t                   cmd_i,
  output egs_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [egs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [W-1:0]                    cfg_data_i,
  input  logic                            in_start_i,
  input  logic [W-1:0]                    in_nonce_i,
  input  logic [egs_pkg::HASH_BITS-1:0]   in_hash_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [W-1:0]                    out_sig_o,
  output logic [W-1:0]                    out_commit_o,
  output logic                            out_status_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] mod_q, key_q, gen_q;
  logic         start_q;
  logic [W-1:0] k_q;
  logic [egs_pkg::HASH_BITS-1:0] h_q;
  logic [W-1:0] commit_q, inv_q;
  logic         bad_q;
  logic [W-1:0] base_q, pacc_q, e_q;
  logic [W-1:0] r0_q, r1_q, t0_q, t1_q, qt_q, rn_q;
  logic [W-1:0] cm_q, xm_q, hm_q, im_q, dd_q, sq_q;
  logic         out_valid_q, out_status_q;
  logic [W-1:0] out_sig_q, out_commit_q;

  logic [W-1:0] m_w;
  logic         usable;

  // restoring divider
  logic          dv_busy_q, dv_done_q;
  logic [CW-1:0] dv_cnt_q;
  logic [W-1:0]  dv_n_q, dv_r_q, dv_d_q;
  logic [W:0]    dv_trial, dv_diff;
  logic          dv_ge;

  // shift and add modular multiplier
  logic          mu_busy_q, mu_done_q;
  logic [CW-1:0] mu_cnt_q;
  logic [W-1:0]  mu_a_q, mu_b_q, mu_m_q, mu_acc_q;
  logic [W:0]    mu_dbl, mu_sum;
  logic [W-1:0]  mu_a2, mu_a3;

  logic         is_div;
  logic [W-1:0] op_n, op_d, op_a, op_b, op_m;

  function automatic logic [W-1:0] sub_m(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] mm);
    sub_m = (a >= b) ? (a - b) : (a + (mm - b));
  endfunction

  assign m_w    = mod_q - W'(1);
  assign usable = mod_q >= W'(2);

  always_comb begin
    is_div = 1'b0;
    op_n   = gen_q;
    op_d   = m_w;
    op_a   = pacc_q;
    op_b   = base_q;
    op_m   = m_w;
    unique case (cmd_i.step)
      egs_pkg::STEP_GMOD: begin
        is_div = 1'b1;
        op_n   = gen_q;
        op_d   = mod_q;
      end
      egs_pkg::STEP_KMOD: begin
        is_div = 1'b1;
        op_n   = k_q;
      end
      egs_pkg::STEP_EDIV: begin
        is_div = 1'b1;
        op_n   = r0_q;
        op_d   = r1_q;
      end
      egs_pkg::STEP_QMOD: begin
        is_div = 1'b1;
        op_n   = qt_q;
      end
      egs_pkg::STEP_CMOD: begin
        is_div = 1'b1;
        op_n   = commit_q;
      end
      egs_pkg::STEP_XMOD: begin
        is_div = 1'b1;
        op_n   = key_q;
      end
      egs_pkg::STEP_HMOD: begin
        is_div = 1'b1;
        op_n   = W'(h_q);
      end
      egs_pkg::STEP_IMOD: begin
        is_div = 1'b1;
        op_n   = inv_q;
      end
      egs_pkg::STEP_PMUL: begin
        op_m = mod_q;
      end
      egs_pkg::STEP_PSQR: begin
        op_a = base_q;
        op_m = mod_q;
      end
      egs_pkg::STEP_EMUL: begin
        op_a = qt_q;
        op_b = t1_q;
      end
      egs_pkg::STEP_RX: begin
        op_a = cm_q;
        op_b = xm_q;
      end
      egs_pkg::STEP_SMUL: begin
        op_a = im_q;
        op_b = dd_q;
      end
      default: ;
    endcase
  end

  assign dv_trial = {dv_r_q, dv_n_q[W-1]};
  assign dv_ge    = dv_trial >= {1'b0, dv_d_q};
  assign dv_diff  = dv_trial - {1'b0, dv_d_q};

  assign mu_dbl = {mu_acc_q, 1'b0};
  assign mu_a2  = (mu_dbl >= {1'b0, mu_m_q}) ? W'(mu_dbl - {1'b0, mu_m_q}) : W'(mu_dbl);
  assign mu_sum = {1'b0, mu_a2} + {1'b0, mu_a_q};
  assign mu_a3  = (mu_sum >= {1'b0, mu_m_q}) ? W'(mu_sum - {1'b0, mu_m_q}) : W'(mu_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_done_q <= 1'b0;
      dv_cnt_q  <= '0;
      mu_busy_q <= 1'b0;
      mu_done_q <= 1'b0;
      mu_cnt_q  <= '0;
    end else begin
      dv_done_q <= 1'b0;
      mu_done_q <= 1'b0;
      if (cmd_i.launch && is_div) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= '0;
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q + CW'(1);
        if (dv_cnt_q == CW'(W - 1)) begin
          dv_busy_q <= 1'b0;
          dv_done_q <= 1'b1;
        end
      end
      if (cmd_i.launch && !is_div) begin
        mu_busy_q <= 1'b1;
        mu_cnt_q  <= '0;
      end else if (mu_busy_q) begin
        mu_cnt_q <= mu_cnt_q + CW'(1);
        if (mu_cnt_q == CW'(W - 1)) begin
          mu_busy_q <= 1'b0;
          mu_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.launch && is_div) begin
      dv_n_q <= op_n;
      dv_d_q <= op_d;
      dv_r_q <= '0;
    end else if (dv_busy_q) begin
      dv_r_q <= dv_ge ? W'(dv_diff) : W'(dv_trial);
      dv_n_q <= {dv_n_q[W-2:0], dv_ge};
    end
    if (cmd_i.launch && !is_div) begin
      mu_a_q   <= op_a;
      mu_b_q   <= op_b;
      mu_m_q   <= op_m;
      mu_acc_q <= '0;
    end else if (mu_busy_q) begin
      mu_acc_q <= mu_b_q[W-1] ? mu_a3 : mu_a2;
      mu_b_q   <= {mu_b_q[W-2:0], 1'b0};
    end
  end

  // configuration, stored nonce state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= W'(3);
      key_q       <= '0;
      gen_q       <= W'(2);
      commit_q    <= '0;
      inv_q       <= '0;
      bad_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          egs_pkg::CFG_MODULUS:     mod_q <= cfg_data_i;
          egs_pkg::CFG_PRIVATE_KEY: key_q <= cfg_data_i;
          egs_pkg::CFG_GENERATOR:   gen_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.write) begin
        unique case (cmd_i.step)
          egs_pkg::STEP_KMOD:  commit_q <= pacc_q;
          egs_pkg::STEP_EFIN: begin
            bad_q <= r0_q != W'(1);
            inv_q <= (r0_q == W'(1)) ? t0_q : '0;
          end
          egs_pkg::STEP_UNUSE: begin
            commit_q <= '0;
            inv_q    <= '0;
            bad_q    <= 1'b1;
          end
          egs_pkg::STEP_OUT:   out_valid_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      start_q <= in_start_i;
      k_q     <= in_nonce_i;
      h_q     <= in_hash_i;
    end
    if (cmd_i.write) begin
      unique case (cmd_i.step)
        egs_pkg::STEP_GMOD: begin
          base_q <= dv_r_q;
          pacc_q <= W'(1);
          e_q    <= k_q;
        end
        egs_pkg::STEP_PMUL: pacc_q <= mu_acc_q;
        egs_pkg::STEP_PSQR: begin
          base_q <= mu_acc_q;
          e_q    <= e_q >> 1;
        end
        egs_pkg::STEP_KMOD: begin
          r1_q <= dv_r_q;
          r0_q <= m_w;
          t0_q <= '0;
          t1_q <= (m_w == W'(1)) ? '0 : W'(1);
        end
        egs_pkg::STEP_EDIV: begin
          qt_q <= dv_n_q;
          rn_q <= dv_r_q;
        end
        egs_pkg::STEP_QMOD: qt_q <= dv_r_q;
        egs_pkg::STEP_EMUL: begin
          t1_q <= sub_m(t0_q, mu_acc_q, m_w);
          t0_q <= t1_q;
          r0_q <= r1_q;
          r1_q <= rn_q;
        end
        egs_pkg::STEP_CMOD: cm_q <= dv_r_q;
        egs_pkg::STEP_XMOD: xm_q <= dv_r_q;
        egs_pkg::STEP_HMOD: hm_q <= dv_r_q;
        egs_pkg::STEP_IMOD: im_q <= dv_r_q;
        egs_pkg::STEP_RX:   dd_q <= sub_m(hm_q, mu_acc_q, m_w);
        egs_pkg::STEP_SMUL: sq_q <= mu_acc_q;
        egs_pkg::STEP_OUT: begin
          out_sig_q    <= (usable && !bad_q) ? sq_q : '0;
          out_commit_q <= commit_q;
          out_status_q <= !(usable && !bad_q);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.usable    = usable;
    sts_o.start     = start_q;
    sts_o.e_zero    = e_q == '0;
    sts_o.e_bit     = e_q[0];
    sts_o.r1_zero   = r1_q == '0;
    sts_o.bad       = bad_q;
    sts_o.unit_done = dv_done_q | mu_done_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sig_o    = out_sig_q;
  assign out_commit_o = out_commit_q;
  assign out_status_o = out_status_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dv_busy_q && mu_busy_q))
    else $error("divider and multiplier busy together");

  a_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.launch |-> (!dv_busy_q && !mu_busy_q))
    else $error("serial unit launched while busy");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && cmd_i.step == egs_pkg::STEP_OUT) |=> out_valid_q)
    else $error("result not presented after output load");

endmodule

// File: src/egs_controller.sv
// controller: sequences the serial steps of one request
`timescale 1ns / 1ps
module egs_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  egs_pkg::sts_t sts_i,
  output egs_pkg::cmd_t cmd_o
);

  egs_pkg::ctl_state_e state_q, state_d;
  logic                busy_q, busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= egs_pkg::ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  always_comb begin
    egs_pkg::ctl_state_e after;
    logic                serial;
    state_d      = state_q;
    busy_d       = busy_q;
    cmd_o.step   = egs_pkg::STEP_NONE;
    cmd_o.launch = 1'b0;
    cmd_o.write  = 1'b0;
    cmd_o.accept = 1'b0;
    in_ready_o   = 1'b0;
    after        = egs_pkg::ST_IDLE;
    serial       = 1'b1;
    unique case (state_q)
      egs_pkg::ST_IDLE: begin
        serial     = 1'b0;
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = egs_pkg::ST_DECIDE;
        end
      end
      egs_pkg::ST_DECIDE: begin
        serial = 1'b0;
        if (sts_i.start) begin
          state_d = sts_i.usable ? egs_pkg::ST_GMOD : egs_pkg::ST_UNUSE;
        end else begin
          state_d = egs_pkg::ST_CHECK;
        end
      end
      egs_pkg::ST_UNUSE: begin
        serial      = 1'b0;
        cmd_o.step  = egs_pkg::STEP_UNUSE;
        cmd_o.write = 1'b1;
        state_d     = egs_pkg::ST_OUT;
      end
      egs_pkg::ST_GMOD: begin
        cmd_o.step = egs_pkg::STEP_GMOD;
        after      = egs_pkg::ST_PLOOP;
      end
      egs_pkg::ST_PLOOP: begin
        serial = 1'b0;
        priority if (sts_i.e_zero) begin
          state_d = egs_pkg::ST_KMOD;
        end else if (sts_i.e_bit) begin
          state_d = egs_pkg::ST_PMUL;
        end else begin
          state_d = egs_pkg::ST_PSQR;
        end
      end
      egs_pkg::ST_PMUL: begin
        cmd_o.step = egs_pkg::STEP_PMUL;
        after      = egs_pkg::ST_PSQR;
      end
      egs_pkg::ST_PSQR: begin
        cmd_o.step = egs_pkg::STEP_PSQR;
        after      = egs_pkg::ST_PLOOP;
      end
      egs_pkg::ST_KMOD: begin
        cmd_o.step = egs_pkg::STEP_KMOD;
        after      = egs_pkg::ST_ELOOP;
      end
      egs_pkg::ST_ELOOP: begin
        serial  = 1'b0;
        state_d = sts_i.r1_zero ? egs_pkg::ST_EFIN : egs_pkg::ST_EDIV;
      end
      egs_pkg::ST_EDIV: begin
        cmd_o.step = egs_pkg::STEP_EDIV;
        after      = egs_pkg::ST_QMOD;
      end
      egs_pkg::ST_QMOD: begin
        cmd_o.step = egs_pkg::STEP_QMOD;
        after      = egs_pkg::ST_EMUL;
      end
      egs_pkg::ST_EMUL: begin
        cmd_o.step = egs_pkg::STEP_EMUL;
        after      = egs_pkg::ST_ELOOP;
      end
      egs_pkg::ST_EFIN: begin
        serial      = 1'b0;
        cmd_o.step  = egs_pkg::STEP_EFIN;
        cmd_o.write = 1'b1;
        state_d     = egs_pkg::ST_CHECK;
      end
      egs_pkg::ST_CHECK: begin
        serial  = 1'b0;
        state_d = (sts_i.usable && !sts_i.bad) ? egs_pkg::ST_CMOD : egs_pkg::ST_OUT;
      end
      egs_pkg::ST_CMOD: begin
        cmd_o.step = egs_pkg::STEP_CMOD;
        after      = egs_pkg::ST_XMOD;
      end
      egs_pkg::ST_XMOD: begin
        cmd_o.step = egs_pkg::STEP_XMOD;
        after      = egs_pkg::ST_HMOD;
      end
      egs_pkg::ST_HMOD: begin
        cmd_o.step = egs_pkg::STEP_HMOD;
        after      = egs_pkg::ST_IMOD;
      end
      egs_pkg::ST_IMOD: begin
        cmd_o.step = egs_pkg::STEP_IMOD;
        after      = egs_pkg::ST_RX;
      end
      egs_pkg::ST_RX: begin
        cmd_o.step = egs_pkg::STEP_RX;
        after      = egs_pkg::ST_SMUL;
      end
      egs_pkg::ST_SMUL: begin
        cmd_o.step = egs_pkg::STEP_SMUL;
        after      = egs_pkg::ST_OUT;
      end
      egs_pkg::ST_OUT: begin
        serial     = 1'b0;
        cmd_o.step = egs_pkg::STEP_OUT;
        if (sts_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = egs_pkg::ST_IDLE;
        end
      end
      default: begin
        serial  = 1'b0;
        state_d = egs_pkg::ST_IDLE;
      end
    endcase
    // serial steps: launch once, then store the unit's result when it reports done
    if (serial) begin
      if (!busy_q) begin
        cmd_o.launch = 1'b1;
        busy_d       = 1'b1;
      end else if (sts_i.unit_done) begin
        cmd_o.write = 1'b1;
        busy_d      = 1'b0;
        state_d     = after;
      end
    end
  end

endmodule

// File: verif/elgamal_bytewise_signer_tb.sv
// self-checking testbench for the bytewise elgamal signer
`timescale 1ns / 1ps
module elgamal_bytewise_signer_tb;

  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [31:0] sig;
    logic [31:0] commit;
    logic        status;
  } sig_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = egs_pkg::CFG_MODULUS;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // nonce, hash_byte
  logic        s_axis_tuser = 1'b0;  // start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // signature_part, commitment
  logic        m_axis_tuser;  // status

  // signer state as the testbench sees it
  longint unsigned cur_modulus = 3, cur_key = 0, cur_gen = 2;
  longint unsigned held_commit = 0, held_inverse = 0;
  bit              held_bad = 1'b1;

  sig_result_t pending_sigs[$];
  int unsigned errors = 0, cycles = 0, sent = 0, checked = 0, starts = 0, bad_status = 0;
  int unsigned burst_left = 0, hold_cycles = 0;
  bit          no_gaps = 1'b0;

  elgamal_bytewise_signer uut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still pending", cycles,
               pending_sigs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: own stall pattern plus a long hold-off on demand
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (cycles % 512 < 128) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    sig_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sigs.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_sigs.pop_front();
        checked++;
        if (m_axis_tuser) bad_status++;
        if (m_axis_tdata[31:0] !== want.sig) begin
          $error("signature_part expected %h got %h", want.sig, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.commit) begin
          $error("commitment expected %h got %h", want.commit, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status expected %b got %b", want.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // extended euclid; 0 when no inverse exists
  function automatic bit inverse_mod(longint unsigned a, longint unsigned m,
                                     output longint unsigned inv);
    longint r0, r1, t0, t1, q, tmp;
    r0 = m;
    r1 = a % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) begin
      inv = 0;
      return 1'b0;
    end
    inv = ((t0 % longint'(m)) + longint'(m)) % longint'(m);
    return 1'b1;
  endfunction

  function automatic sig_result_t sign_byte(bit start, longint unsigned k, longint unsigned h);
    sig_result_t res;
    bit usable;
    longint unsigned m, inv, rx, d;
    usable = cur_modulus >= 2;
    m = cur_modulus - 1;
    if (start) begin
      if (usable) begin
        held_commit = pow_mod(cur_gen, k, cur_modulus);
        held_bad = !inverse_mod(k, m, inv);
        held_inverse = inv;
      end else begin
        held_commit = 0;
        held_inverse = 0;
        held_bad = 1'b1;
      end
    end
    res.sig = '0;
    res.commit = held_commit[31:0];
    res.status = 1'b1;
    if (usable && !held_bad) begin
      rx = mul_mod(held_commit, cur_key, m);
      d = ((h % m) + m - rx) % m;
      res.sig = 32'(mul_mod(held_inverse, d, m));
      res.status = 1'b0;
    end
    return res;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      egs_pkg::CFG_MODULUS: cur_modulus = 64'(value);
      egs_pkg::CFG_PRIVATE_KEY: cur_key = 64'(value);
      egs_pkg::CFG_GENERATOR: cur_gen = 64'(value);
      default: ;
    endcase
  endtask

  task automatic send_item(bit start, logic [31:0] k, logic [7:0] h);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0 && !no_gaps) begin
      gap = $urandom_range(0, 6);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = start;
    s_axis_tdata = {h, k};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_sigs.push_back(sign_byte(start, 64'(k), 64'(h)));
    sent++;
    if (start) starts++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_sigs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic setup(logic [31:0] p, logic [31:0] x, logic [31:0] g);
    write_reg(egs_pkg::CFG_MODULUS, p);
    write_reg(egs_pkg::CFG_PRIVATE_KEY, x);
    write_reg(egs_pkg::CFG_GENERATOR, g);
  endtask

  task automatic test_no_nonce();
    send_item(1'b0, 32'hFFFF_FFFF, 8'h00);
    send_item(1'b0, 32'h0, 8'hFF);
    drain();
  endtask

  task automatic test_directed();
    setup(32'd11, 32'd7, 32'd2);
    send_item(1'b1, 32'd3, 8'h00);
    send_item(1'b0, 32'd0, 8'hFF);
    send_item(1'b1, 32'd5, 8'h5A);  // gcd with 10 not one
    send_item(1'b0, 32'd0, 8'h12);
    send_item(1'b1, 32'd0, 8'h34);
    send_item(1'b1, 32'hFFFF_FFFF, 8'hA5);
    drain();
    // registers changed after a start keep the stored nonce
    write_reg(egs_pkg::CFG_PRIVATE_KEY, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0, 8'h80);
    drain();
    setup(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_item(1'b1, 32'd1, 8'h00);
    drain();
    write_reg(egs_pkg::CFG_MODULUS, 32'd2);  // p-1 is one
    send_item(1'b1, 32'd6, 8'h77);
    send_item(1'b0, 32'd0, 8'h01);
    drain();
    write_reg(egs_pkg::CFG_MODULUS, 32'd1);
    send_item(1'b0, 32'd0, 8'h02);
    send_item(1'b1, 32'd9, 8'h03);
    drain();
    write_reg(egs_pkg::CFG_MODULUS, 32'd0);
    send_item(1'b1, 32'd9, 8'h04);
    drain();
    setup(32'd15, 32'd4, 32'd0);  // composite modulus, zero generator
    send_item(1'b1, 32'd3, 8'hC3);
    send_item(1'b0, 32'd0, 8'h3C);
    send_item(1'b1, 32'd0, 8'hC3);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] primes[8] = '{32'd3, 32'd5, 32'd13, 32'd251, 32'd65521, 32'd2147483647,
                               32'hFFFF_FFFB, 32'd1000003};
    logic [31:0] p, k;
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 9))
        0: p = $urandom();
        1: p = $urandom_range(0, 2);
        2: p = 32'hFFFF_FFFF;
        default: p = primes[$urandom_range(0, 7)];
      endcase
      no_gaps = (ph % 4 == 3);
      setup(p, ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom(), $urandom());
      for (int i = 0; i < 30; i++) begin
        case ($urandom_range(0, 3))
          0: k = $urandom_range(0, 64);
          1: k = (p > 1) ? (p - 1) * $urandom_range(0, 3) : $urandom();
          default: k = $urandom();
        endcase
        send_item(i == 0 || $urandom_range(0, 9) == 0, k, 8'($urandom_range(0, 255)));
      end
      drain();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    setup(32'd65521, $urandom(), 32'd3);
    no_gaps = 1'b1;
    @(negedge clk_i);
    // long enough to outlast a full nonce load plus a second request
    hold_cycles = 12000;
    send_item(1'b1, $urandom(), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 12; i++) send_item(1'b0, 32'd0, 8'($urandom_range(0, 255)));
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_no_nonce();
    test_directed();
    test_random();
    test_backpressure();
    repeat (300) @(posedge clk_i);
    $display("sent %0d requests (%0d nonce loads) over many modulus settings,", sent, starts);
    $display("checked %0d results, %0d with bad-nonce status", checked, bad_status);
    if (errors == 0 && pending_sigs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/egs_pkg.sv
src/egs_datapath.sv
src/egs_controller.sv
src/elgamal_bytewise_signer.sv
verif/elgamal_bytewise_signer_tb.sv
